@@ sv/stc_pkg.sv @@
package stc_pkg;

    localparam int TICKS_PER_SECOND = 1000;
    localparam int TIMER_W          = 18;
    localparam int ADDR_W           = 32;
    localparam int DUR_W            = 8;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 32;

    typedef enum logic [2:0] {
        ACT_UP          = 3'd0,
        ACT_DOWN        = 3'd1,
        ACT_STOP        = 3'd2,
        ACT_TOGGLE_UP   = 3'd3,
        ACT_TOGGLE_DOWN = 3'd4,
        ACT_LOCK        = 3'd5,
        ACT_UNLOCK      = 3'd6,
        ACT_UNSUPPORTED = 3'd7
    } act_code_t;

    typedef enum logic {
        REQ_ACTION = 1'b0,
        REQ_TICK   = 1'b1
    } req_t;

    typedef enum logic [2:0] {
        COND_STOPPED    = 3'd0,
        COND_RISING     = 3'd1,
        COND_DESCENDING = 3'd2,
        COND_UP         = 3'd3,
        COND_DOWN       = 3'd4
    } cond_t;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        CMD_STOP  = 2'd0,
        CMD_OPEN  = 2'd1,
        CMD_CLOSE = 2'd2
    } cmd_t;

    typedef enum logic {
        EVT_UP_REACHED   = 1'b0,
        EVT_DOWN_REACHED = 1'b1
    } evt_dir_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEVICE_ADDRESS = 1'b0,
        CFG_TRAVEL_SECONDS = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic              req_type;
        logic [2:0]        action_code;
        logic              has_override;
        logic [DUR_W-1:0]  override_byte;
    } stc_in_t;

    typedef struct packed {
        logic              accepted;
        logic              send_valid;
        logic [1:0]        motor_command;
        logic [DUR_W-1:0]  message_duration;
        logic [ADDR_W-1:0] message_address;
        logic              event_valid;
        logic              event_dir;
        logic [2:0]        condition_state;
        logic              locked_state;
    } stc_out_t;

    // handshake between pipeline stages
    typedef struct packed {
        logic valid;
        logic ready;
    } stc_hs_t;

endpackage

@@ sv/stc_in_stage.sv @@
module stc_in_stage
    import stc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  stc_in_t in_data,
    input  logic    down_ready,
    output logic    item_valid,
    output stc_in_t item
);

    logic    valid_reg;
    stc_in_t data_reg;
    logic    load;

    assign in_stall   = valid_reg && !down_ready;
    assign load       = in_valid && !in_stall;
    assign item_valid = valid_reg;
    assign item       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (down_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= in_data;
        end
    end

endmodule

@@ sv/stc_step.sv @@
module stc_step
    import stc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  fire,
    input  stc_in_t               item,
    output stc_out_t              result
);

    logic [ADDR_W-1:0]  device_address_reg;
    logic [DUR_W-1:0]   travel_seconds_reg;
    cond_t              condition_reg, condition_next;
    logic               lock_reg, lock_next;
    dir_t               last_dir_reg, last_dir_next;
    logic               timer_active_reg, timer_active_next;
    logic [TIMER_W-1:0] timer_rem_reg, timer_rem_next;

    logic [TIMER_W-1:0] timer_load;
    cmd_t               cmd;
    logic               expire;

    // 255 s * 1000 still fits in the 18-bit timer
    assign timer_load = TIMER_W'({{(TIMER_W-DUR_W){1'b0}}, travel_seconds_reg}
                                 * TIMER_W'(TICKS_PER_SECOND));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= '0;
            travel_seconds_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_DEVICE_ADDRESS: device_address_reg <= cfg_data[ADDR_W-1:0];
                CFG_TRAVEL_SECONDS: travel_seconds_reg <= cfg_data[DUR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        condition_next    = condition_reg;
        lock_next         = lock_reg;
        last_dir_next     = last_dir_reg;
        timer_active_next = timer_active_reg;
        timer_rem_next    = timer_rem_reg;
        result            = '0;
        result.accepted   = 1'b1;
        cmd               = CMD_STOP;
        expire            = 1'b0;

        if (req_t'(item.req_type) == REQ_TICK)
        begin
            if (timer_active_reg)
            begin
                expire = (timer_rem_reg <= TIMER_W'(1));
                if (timer_rem_reg != '0)
                begin
                    timer_rem_next = timer_rem_reg - TIMER_W'(1);
                end
                if (expire)
                begin
                    timer_active_next = 1'b0;
                    timer_rem_next    = '0;
                    condition_next    = COND_STOPPED;
                    case (last_dir_reg)
                        DIR_UP:
                        begin
                            condition_next     = COND_UP;
                            result.event_valid = 1'b1;
                            result.event_dir   = EVT_UP_REACHED;
                        end
                        DIR_DOWN:
                        begin
                            condition_next     = COND_DOWN;
                            result.event_valid = 1'b1;
                            result.event_dir   = EVT_DOWN_REACHED;
                        end
                        default: ;
                    endcase
                    last_dir_next = DIR_STOP;
                end
            end
        end
        else
        begin
            case (act_code_t'(item.action_code))
                ACT_LOCK:        lock_next = 1'b1;
                ACT_UNLOCK:      lock_next = 1'b0;
                ACT_UNSUPPORTED: result.accepted = 1'b0;
                default:
                begin
                    case (act_code_t'(item.action_code))
                        ACT_UP:   cmd = CMD_OPEN;
                        ACT_DOWN: cmd = CMD_CLOSE;
                        ACT_TOGGLE_UP:
                            cmd = (condition_reg == COND_STOPPED ||
                                   condition_reg == COND_DOWN) ? CMD_OPEN : CMD_STOP;
                        ACT_TOGGLE_DOWN:
                            cmd = (condition_reg == COND_STOPPED ||
                                   condition_reg == COND_UP) ? CMD_CLOSE : CMD_STOP;
                        default:  cmd = CMD_STOP;
                    endcase

                    // any movement request kills the running timer, locked or not
                    timer_active_next = 1'b0;
                    timer_rem_next    = '0;

                    if (!lock_reg)
                    begin
                        case (cmd)
                            CMD_OPEN:
                            begin
                                condition_next    = COND_RISING;
                                last_dir_next     = DIR_UP;
                                timer_active_next = 1'b1;
                                timer_rem_next    = timer_load;
                            end
                            CMD_CLOSE:
                            begin
                                condition_next    = COND_DESCENDING;
                                last_dir_next     = DIR_DOWN;
                                timer_active_next = 1'b1;
                                timer_rem_next    = timer_load;
                            end
                            default:
                            begin
                                condition_next = COND_STOPPED;
                                last_dir_next  = DIR_STOP;
                            end
                        endcase
                        result.send_valid       = 1'b1;
                        result.motor_command    = cmd;
                        result.message_duration = item.has_override ? item.override_byte
                                                                    : travel_seconds_reg;
                        result.message_address  = device_address_reg;
                    end
                end
            endcase
        end

        result.condition_state = condition_next;
        result.locked_state    = lock_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            condition_reg    <= COND_STOPPED;
            lock_reg         <= 1'b0;
            last_dir_reg     <= DIR_STOP;
            timer_active_reg <= 1'b0;
            timer_rem_reg    <= '0;
        end
        else if (fire)
        begin
            condition_reg    <= condition_next;
            lock_reg         <= lock_next;
            last_dir_reg     <= last_dir_next;
            timer_active_reg <= timer_active_next;
            timer_rem_reg    <= timer_rem_next;
        end
    end

endmodule

@@ sv/stc_out_stage.sv @@
module stc_out_stage
    import stc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  stc_hs_t  up,
    output logic     fire,
    input  stc_out_t result,
    output logic     out_valid,
    input  logic     out_stall,
    output stc_out_t out_data
);

    logic     valid_reg;
    stc_out_t data_reg;

    assign fire      = up.valid && up.ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up.ready)
        begin
            valid_reg <= up.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            data_reg <= result;
        end
    end

endmodule

@@ sv/shutter_travel_controller_core.sv @@
// Roller-shutter travel controller. Each input transaction is either an
// action (up, down, stop, toggle up/down, lock, unlock) or a 1 ms tick, and
// each one yields exactly one result transaction carrying the motor message
// (when one is sent), the end-of-travel event (when the timer runs out) and
// the condition and lock flag after the transaction. Throughput is one
// transaction per clock unless the result stalls: the transaction sits in
// an input register, the state update and result are computed in one short
// combinational pass and land in the result register the same cycle the
// controller state moves on. A stalled result register backs up into the
// input register and then into in_stall. The user must write configuration
// (device_address at index 0, travel_seconds at index 1) through cfg_we/
// cfg_index/cfg_data only while no transaction is in flight; the block does
// not enforce this. The travel timer loads travel_seconds * 1000 ticks.
module shutter_travel_controller_core
    import stc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  stc_in_t               in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output stc_out_t              out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    stc_hs_t  hs;
    stc_in_t  item;
    stc_out_t result;
    logic     fire;

    // result register can take a new value when empty or being drained
    assign hs.ready = !out_valid || !out_stall;

    stc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .down_ready (hs.ready),
        .item_valid (hs.valid),
        .item       (item)
    );

    // controller state and per-transaction logic
    stc_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .item      (item),
        .result    (result)
    );

    stc_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .up        (hs),
        .fire      (fire),
        .result    (result),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

@@ tb/shutter_travel_controller_core_test.sv @@
`timescale 1ns / 1ps

module shutter_travel_controller_core_test;

    import stc_pkg::*;

    // ------------------------------------------------------------------
    // Expected-report book: tracks the controller state on its own and
    // queues one expected report per accepted request transaction.
    // ------------------------------------------------------------------
    class shutter_book;

        logic [ADDR_W-1:0]  dest_addr;
        logic [DUR_W-1:0]   travel_s;
        cond_t              cond;
        logic               locked;
        dir_t               heading;
        logic               timer_on;
        logic [TIMER_W-1:0] timer_left;
        stc_out_t           awaited[$];
        int                 mismatches;

        function new();
            dest_addr  = '0;
            travel_s   = '0;
            cond       = COND_STOPPED;
            locked     = 1'b0;
            heading    = DIR_STOP;
            timer_on   = 1'b0;
            timer_left = '0;
            mismatches = 0;
        endfunction

        function void apply_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_DEVICE_ADDRESS)
                dest_addr = value[ADDR_W-1:0];
            else
                travel_s = value[DUR_W-1:0];
        endfunction

        function void arm_timer();
            timer_on   = 1'b1;
            timer_left = TIMER_W'(int'(travel_s) * TICKS_PER_SECOND);
        endfunction

        // Advance the tracked state by one request, return the report it yields.
        function stc_out_t predict_report(stc_in_t req);
            stc_out_t rpt;
            cmd_t     motor;
            logic     runs_out;
            rpt          = '0;
            rpt.accepted = 1'b1;
            if (req.req_type == REQ_TICK)
            begin
                if (timer_on)
                begin
                    // expires on the tick that reaches zero, or at once if loaded with zero
                    runs_out = (timer_left <= 1);
                    if (timer_left != 0)
                        timer_left = timer_left - 1'b1;
                    if (runs_out)
                    begin
                        timer_on   = 1'b0;
                        timer_left = '0;
                        cond       = COND_STOPPED;
                        if (heading == DIR_UP)
                        begin
                            cond            = COND_UP;
                            rpt.event_valid = 1'b1;
                            rpt.event_dir   = EVT_UP_REACHED;
                        end
                        else if (heading == DIR_DOWN)
                        begin
                            cond            = COND_DOWN;
                            rpt.event_valid = 1'b1;
                            rpt.event_dir   = EVT_DOWN_REACHED;
                        end
                        heading = DIR_STOP;
                    end
                end
            end
            else
            begin
                case (act_code_t'(req.action_code))
                    ACT_LOCK:        locked = 1'b1;
                    ACT_UNLOCK:      locked = 1'b0;
                    ACT_UNSUPPORTED: rpt.accepted = 1'b0;
                    default:
                    begin
                        case (act_code_t'(req.action_code))
                            ACT_UP:        motor = CMD_OPEN;
                            ACT_DOWN:      motor = CMD_CLOSE;
                            ACT_STOP:      motor = CMD_STOP;
                            ACT_TOGGLE_UP:
                                motor = (cond == COND_STOPPED || cond == COND_DOWN) ?
                                        CMD_OPEN : CMD_STOP;
                            default:
                                motor = (cond == COND_STOPPED || cond == COND_UP) ?
                                        CMD_CLOSE : CMD_STOP;
                        endcase
                        // any movement cancels the timer, locked or not
                        timer_on   = 1'b0;
                        timer_left = '0;
                        if (!locked)
                        begin
                            if (motor == CMD_OPEN)
                            begin
                                cond    = COND_RISING;
                                heading = DIR_UP;
                                arm_timer();
                            end
                            else if (motor == CMD_CLOSE)
                            begin
                                cond    = COND_DESCENDING;
                                heading = DIR_DOWN;
                                arm_timer();
                            end
                            else
                            begin
                                cond    = COND_STOPPED;
                                heading = DIR_STOP;
                            end
                            rpt.send_valid       = 1'b1;
                            rpt.motor_command    = motor;
                            rpt.message_duration = req.has_override ? req.override_byte
                                                                    : travel_s;
                            rpt.message_address  = dest_addr;
                        end
                    end
                endcase
            end
            rpt.condition_state = cond;
            rpt.locked_state    = locked;
            return rpt;
        endfunction

        function void note_request(stc_in_t req);
            awaited.push_back(predict_report(req));
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_report(stc_out_t got);
            stc_out_t want;
            if (awaited.size() == 0)
            begin
                $error("report transaction with nothing expected: 0x%0h", got);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            compare_field("accepted",         want.accepted,         got.accepted);
            compare_field("send_valid",       want.send_valid,       got.send_valid);
            compare_field("motor_command",    want.motor_command,    got.motor_command);
            compare_field("message_duration", want.message_duration, got.message_duration);
            compare_field("message_address",  want.message_address,  got.message_address);
            compare_field("event_valid",      want.event_valid,      got.event_valid);
            compare_field("event_dir",        want.event_dir,        got.event_dir);
            compare_field("condition_state",  want.condition_state,  got.condition_state);
            compare_field("locked_state",     want.locked_state,     got.locked_state);
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

    endclass

    // ------------------------------------------------------------------
    // Clock, reset and DUT hookup
    // ------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    stc_in_t               in_data;
    logic                  out_valid;
    logic                  out_stall;
    stc_out_t              out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    shutter_book book = new();

    // when set, neither side inserts gaps or stalls
    bit calm;

    shutter_travel_controller_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // Monitor: both handshakes sampled at the rising edge, pre-update values.
    // A request is noted before a report is checked in the same edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                book.note_request(in_data);
            if (out_valid && !out_stall)
                book.check_report(out_data);
        end
    end

    // Result-side back-pressure: random stall bursts, driven at the falling edge.
    initial
    begin
        int burst;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            burst = pick_gap();
            if (burst > 0)
            begin
                out_stall = 1'b1;
                repeat (burst) @(negedge clk);
            end
            out_stall = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    end

    // Hard limit on run length.
    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver tasks. Every task starts and ends at a falling edge.
    // ------------------------------------------------------------------

    // Present one request transaction and hold it until accepted. Valid is
    // left high afterwards; the next call either replaces the payload or
    // drops valid for a gap.
    task automatic send_request(input stc_in_t req);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  = req;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Drain: stop sending and wait for every expected report, then let the
    // two-stage pipe settle.
    task automatic wait_drained();
        in_valid = 1'b0;
        while (book.outstanding() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        book.apply_register(idx, value);
        @(negedge clk);
        cfg_we    = 1'b0;
        cfg_data  = $urandom;
    endtask

    task automatic set_config(input logic [ADDR_W-1:0] addr, input logic [DUR_W-1:0] secs);
        write_register(CFG_DEVICE_ADDRESS, addr);
        write_register(CFG_TRAVEL_SECONDS, CFG_DATA_W'(secs));
    endtask

    function automatic stc_in_t action_req(act_code_t code, logic ovr_en, logic [7:0] ovr);
        stc_in_t req;
        req.req_type      = REQ_ACTION;
        req.action_code   = code;
        req.has_override  = ovr_en;
        req.override_byte = ovr;
        return req;
    endfunction

    // Tick with random filler in the fields a tick ignores.
    function automatic stc_in_t tick_req();
        stc_in_t req;
        req          = $bits(stc_in_t)'($urandom);
        req.req_type = REQ_TICK;
        return req;
    endfunction

    // Tick with every ignored field set to all ones.
    function automatic stc_in_t ones_tick_req();
        stc_in_t req;
        req          = '1;
        req.req_type = REQ_TICK;
        return req;
    endfunction

    // Random mix: ticks, movement with random duration bytes, lock/unlock
    // and the odd unsupported code.
    function automatic stc_in_t random_request();
        stc_in_t req;
        int      roll;
        req  = $bits(stc_in_t)'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 40)
            req.req_type = REQ_TICK;
        else
        begin
            req.req_type = REQ_ACTION;
            if (roll < 76)
                req.action_code = 3'($urandom_range(int'(ACT_UP), int'(ACT_TOGGLE_DOWN)));
            else if (roll < 86)
                req.action_code = ACT_LOCK;
            else if (roll < 96)
                req.action_code = ACT_UNLOCK;
            else
                req.action_code = ACT_UNSUPPORTED;
        end
        return req;
    endfunction

    task automatic random_phase(input int count);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 49) == 0)
                calm = !calm;
            // occasional full drain mid-stream
            if ($urandom_range(0, 99) == 0)
                wait_drained();
            send_request(random_request());
        end
        calm = 1'b0;
    endtask

    // One full travel with a 1 s timer: move, then 1000 to 1003 ticks with
    // lock/unlock/unsupported sprinkled in (none of them stop the timer).
    task automatic full_travel_run();
        stc_in_t side;
        int      ticks;
        int      target;
        ticks  = 0;
        target = 1000 + $urandom_range(0, 3);
        send_request(action_req(ACT_UNLOCK, 1'b0, 8'h00));
        send_request(action_req($urandom_range(0, 1) ? ACT_UP : ACT_DOWN,
                                1'($urandom_range(0, 1)), 8'($urandom)));
        while (ticks < target)
        begin
            if ($urandom_range(0, 49) == 0)
            begin
                side = random_request();
                side.req_type    = REQ_ACTION;
                side.action_code = 3'($urandom_range(int'(ACT_LOCK), int'(ACT_UNSUPPORTED)));
                send_request(side);
            end
            else
            begin
                send_request(tick_req());
                ticks++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        calm      = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_DEVICE_ADDRESS;
        cfg_data  = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: zero travel time so every timer expires on its first tick.
        set_config(32'hFFFF_FFFF, 8'd0);
        send_request(ones_tick_req());                             // idle tick, all ones
        send_request(action_req(ACT_UNSUPPORTED, 1'b1, 8'hFF));
        send_request(action_req(ACT_UP, 1'b1, 8'h00));
        send_request(tick_req());                                  // up reached
        send_request(action_req(ACT_TOGGLE_UP, 1'b0, 8'h00));      // from up: stop
        send_request(action_req(ACT_TOGGLE_DOWN, 1'b0, 8'h55));    // from stopped: close
        send_request(tick_req());                                  // down reached
        send_request(action_req(ACT_TOGGLE_UP, 1'b1, 8'hAA));      // from down: open
        send_request(action_req(ACT_TOGGLE_DOWN, 1'b0, 8'h00));    // while rising: stop
        send_request(action_req(ACT_DOWN, 1'b1, 8'hFF));
        send_request(action_req(ACT_LOCK, 1'b0, 8'h00));
        send_request(tick_req());                                  // expires while locked
        send_request(action_req(ACT_UNLOCK, 1'b0, 8'h00));
        send_request(action_req(ACT_UP, 1'b0, 8'h00));
        send_request(action_req(ACT_LOCK, 1'b1, 8'h81));
        send_request(action_req(ACT_DOWN, 1'b1, 8'h0F));           // locked: cancels timer only
        send_request(tick_req());                                  // nothing expires
        send_request(action_req(ACT_TOGGLE_UP, 1'b0, 8'h00));
        send_request(action_req(ACT_STOP, 1'b0, 8'h00));
        send_request(action_req(ACT_UNLOCK, 1'b0, 8'h00));
        send_request(action_req(ACT_STOP, 1'b1, 8'hF0));
        send_request(tick_req());
        send_request(action_req(ACT_UP, 1'b0, 8'hFF));             // default duration byte
        send_request(action_req(ACT_UNSUPPORTED, 1'b0, 8'h00));    // timer left running
        send_request(tick_req());
        wait_drained();

        // Random phases across register settings, extremes included.
        set_config(32'h0000_0000, 8'd0);
        random_phase(60);
        wait_drained();

        set_config(32'hFFFF_FFFF, 8'd255);
        random_phase(60);
        wait_drained();

        set_config($urandom, 8'd1);
        full_travel_run();
        random_phase(30);
        wait_drained();

        set_config($urandom, 8'($urandom_range(2, 254)));
        random_phase(50);
        wait_drained();

        set_config($urandom, 8'd0);
        random_phase(60);

        // Wind down: everything back, then a margin for stray reports.
        in_valid = 1'b0;
        while (book.outstanding() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (book.outstanding() != 0)
        begin
            $error("%0d expected report transactions never arrived", book.outstanding());
            book.mismatches++;
        end

        if (book.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
